FILE: hdl/assert_macros.svh
// Assertion macros shared by the line breaker RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/gmlb_pkg.sv
// Package for the greedy monospace line breaker: register codes, break rules
// and the break codepoint table. No dependencies.
`default_nettype none

package gmlb_pkg;

    // Register indexes on the configuration port (word address bits).
    typedef enum logic [1:0] {
        REG_WRAP_POLICY   = 2'd0,
        REG_SIZING_MODE   = 2'd1,
        REG_CONSTRAINT_OK = 2'd2,
        REG_GLYPHS_FIT    = 2'd3
    } t_reg_idx;

    // Wrap policy codes.
    localparam logic [1:0] WRAP_NONE = 2'd0;
    localparam logic [1:0] WRAP_WORD = 2'd1;
    localparam logic [1:0] WRAP_CHAR = 2'd2;

    // Width mode codes.
    localparam logic [1:0] MODE_UNDEF = 2'd0;
    localparam logic [1:0] MODE_MIN   = 2'd3;

    // Effective break rule derived from the registers.
    typedef enum logic [1:0] {
        RULE_ONE  = 2'd0,   // whole text is one line
        RULE_WORD = 2'd1,   // greedy word wrap at the limit
        RULE_CHAR = 2'd2,   // character wrap at the limit
        RULE_BRK  = 2'd3    // line ends after every break glyph
    } t_rule;

    localparam int CP_BITS  = 21;
    localparam int FIT_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam int NUM_BRK  = 14;

    typedef logic [CP_BITS-1:0] t_cp;

    localparam t_cp BRK_CODES [NUM_BRK] = '{
        21'h000020, 21'h000009, 21'h00002d, 21'h00002c, 21'h00002e,
        21'h00003b, 21'h00003a, 21'h00002f, 21'h0000b7, 21'h00200b,
        21'h003001, 21'h003002, 21'h00ff0c, 21'h00ff0e
    };

    // True when a break is allowed after this codepoint.
    function automatic logic is_brk(input t_cp cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_BRK; i++) begin
            hit = hit | (cp == BRK_CODES[i]);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/greedy_monospace_line_breaker.sv
// The transaction ending a text passes the input register, then its result is registered.
// Throughput: one glyph per cycle when not stalled; the single counter-update stage sets the rate.
// The input register stalls only when a result is due and the output register is full and not taken.
// Reset (i_rst_n low, synchronous) clears the configuration registers, the line counters
// and the valid flags.
// Depends on gmlb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module greedy_monospace_line_breaker #(
    parameter int LEN_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Glyph stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [20:0] codepoint, [23:21] zero
    input  wire logic        s_axis_tlast,   // last_glyph
    input  wire logic [0:0]  s_axis_tuser,   // [0] no_glyph
    // Report stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata    // [15:0] line_total, [31:16] longest_line
);

    localparam int CW = (LEN_BITS > gmlb_pkg::FIT_BITS) ? LEN_BITS : gmlb_pkg::FIT_BITS;
    localparam logic [LEN_BITS-1:0] CNT_MAX = {LEN_BITS{1'b1}};
    localparam logic [CW-1:0] OUT_MAX = CW'({gmlb_pkg::OUT_BITS{1'b1}});

    // Configuration registers
    logic [1:0]  r_wrap_policy;
    logic [1:0]  r_sizing_mode;
    logic        r_constraint_ok;
    logic [15:0] r_glyphs_fit;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_policy   <= '0;
            r_sizing_mode   <= '0;
            r_constraint_ok <= 1'b0;
            r_glyphs_fit    <= '0;
        end else if (cfg_wr) begin
            unique case (gmlb_pkg::t_reg_idx'(paddr[3:2]))
                gmlb_pkg::REG_WRAP_POLICY:   r_wrap_policy   <= pwdata[1:0];
                gmlb_pkg::REG_SIZING_MODE:   r_sizing_mode   <= pwdata[1:0];
                gmlb_pkg::REG_CONSTRAINT_OK: r_constraint_ok <= pwdata[0];
                gmlb_pkg::REG_GLYPHS_FIT:    r_glyphs_fit    <= pwdata[15:0];
                default:                     r_glyphs_fit    <= r_glyphs_fit;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (gmlb_pkg::t_reg_idx'(paddr[3:2]))
            gmlb_pkg::REG_WRAP_POLICY:   prdata = {30'd0, r_wrap_policy};
            gmlb_pkg::REG_SIZING_MODE:   prdata = {30'd0, r_sizing_mode};
            gmlb_pkg::REG_CONSTRAINT_OK: prdata = {31'd0, r_constraint_ok};
            gmlb_pkg::REG_GLYPHS_FIT:    prdata = {16'd0, r_glyphs_fit};
            default:                     prdata = '0;
        endcase
    end

    // Input register and pipeline handshake.
    logic             r_in_valid;
    gmlb_pkg::t_cp    r_in_cp;
    logic             r_in_none;
    logic             r_in_last;
    logic             r_out_valid;
    logic [15:0]      r_out_total;
    logic [15:0]      r_out_longest;
    logic             report;
    logic             advance;

    assign report        = r_in_none | r_in_last;
    assign advance       = r_in_valid & (!report | !r_out_valid | m_axis_tready);
    assign s_axis_tready = !r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cp   <= s_axis_tdata[gmlb_pkg::CP_BITS-1:0];
            r_in_none <= s_axis_tuser[0];
            r_in_last <= s_axis_tlast;
        end
    end

    // Break rule and line limit from the registers.
    gmlb_pkg::t_rule rule;
    logic [15:0]     limit;

    always_comb begin
        limit = 16'd1;
        if (r_sizing_mode == gmlb_pkg::MODE_MIN) begin
            if (r_wrap_policy == gmlb_pkg::WRAP_NONE) begin
                rule = gmlb_pkg::RULE_ONE;
            end else if (r_wrap_policy == gmlb_pkg::WRAP_CHAR) begin
                rule = gmlb_pkg::RULE_CHAR;
            end else begin
                rule = gmlb_pkg::RULE_BRK;
            end
        end else if (r_sizing_mode == gmlb_pkg::MODE_UNDEF
                     || r_wrap_policy == gmlb_pkg::WRAP_NONE || !r_constraint_ok) begin
            rule = gmlb_pkg::RULE_ONE;
        end else begin
            limit = (r_glyphs_fit == 16'd0) ? 16'd1 : r_glyphs_fit;
            rule  = (r_wrap_policy == gmlb_pkg::WRAP_WORD) ? gmlb_pkg::RULE_WORD
                                                           : gmlb_pkg::RULE_CHAR;
        end
    end

    // Line state
    logic [LEN_BITS-1:0] r_cur, r_brk, r_lines, r_max;
    logic [LEN_BITS-1:0] n_cur, n_brk, n_lines, n_max;

    // Glyph step: limit break, count the glyph, then a min-content break.
    logic                brk_hit, lim_hit, word_back;
    logic [LEN_BITS-1:0] close_len, base, lines1, max1, cur2, brk2;
    logic [LEN_BITS-1:0] g_cur, g_brk, g_lines, g_max;

    always_comb begin
        brk_hit   = gmlb_pkg::is_brk(r_in_cp);
        lim_hit   = (rule == gmlb_pkg::RULE_WORD || rule == gmlb_pkg::RULE_CHAR)
                    && (CW'(r_cur) >= CW'(limit));
        word_back = (rule == gmlb_pkg::RULE_WORD) && (r_brk != '0);
        close_len = word_back ? r_brk : r_cur;
        if (lim_hit) begin
            base   = word_back ? (r_cur - r_brk) : '0;
            lines1 = (r_lines == CNT_MAX) ? r_lines : r_lines + LEN_BITS'(1);
            max1   = (close_len > r_max) ? close_len : r_max;
        end else begin
            base   = r_cur;
            lines1 = r_lines;
            max1   = r_max;
        end
        cur2 = (base == CNT_MAX) ? base : base + LEN_BITS'(1);
        brk2 = brk_hit ? cur2 : (lim_hit ? '0 : r_brk);
        if (rule == gmlb_pkg::RULE_BRK && brk_hit) begin
            g_cur   = '0;
            g_brk   = '0;
            g_lines = (lines1 == CNT_MAX) ? lines1 : lines1 + LEN_BITS'(1);
            g_max   = (cur2 > max1) ? cur2 : max1;
        end else begin
            g_cur   = cur2;
            g_brk   = brk2;
            g_lines = lines1;
            g_max   = max1;
        end
    end

    // Report from the state after the glyph (or as it stands when no glyph).
    logic [LEN_BITS-1:0] s_cur, s_lines, s_max, tot1, long1;
    logic [CW-1:0]       tot_w, long_w;

    always_comb begin
        s_cur   = r_in_none ? r_cur   : g_cur;
        s_lines = r_in_none ? r_lines : g_lines;
        s_max   = r_in_none ? r_max   : g_max;
        if (s_cur != '0) begin
            tot1  = (s_lines == CNT_MAX) ? s_lines : s_lines + LEN_BITS'(1);
            long1 = (s_cur > s_max) ? s_cur : s_max;
        end else begin
            tot1  = s_lines;
            long1 = s_max;
        end
        if (tot1 == '0) begin
            tot1 = LEN_BITS'(1);
        end
        tot_w  = CW'(tot1);
        long_w = CW'(long1);
        if (tot_w > OUT_MAX) begin
            tot_w = OUT_MAX;
        end
        if (long_w > OUT_MAX) begin
            long_w = OUT_MAX;
        end
    end

    // Next state: cleared after a report, else the glyph step.
    always_comb begin
        if (report) begin
            n_cur   = '0;
            n_brk   = '0;
            n_lines = '0;
            n_max   = '0;
        end else begin
            n_cur   = g_cur;
            n_brk   = g_brk;
            n_lines = g_lines;
            n_max   = g_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_brk   <= '0;
            r_lines <= '0;
            r_max   <= '0;
        end else if (advance) begin
            r_cur   <= n_cur;
            r_brk   <= n_brk;
            r_lines <= n_lines;
            r_max   <= n_max;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && report) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && report) begin
            r_out_total   <= tot_w[15:0];
            r_out_longest <= long_w[15:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_longest, r_out_total};

    // Checks
    `ASSERT_NEVER(a_brk_le_cur, r_brk > r_cur, "break length exceeds open line length")
    `ASSERT_CLK(a_total_nonzero, r_out_valid |-> (r_out_total != 16'd0),
                "report with zero line total")
    `ASSERT_CLK(a_stall_cause, (r_in_valid && !advance) |-> (r_out_valid && !m_axis_tready),
                "input stage stalled without a full output register")
    `ASSERT_CLK(a_clear_after_report, (advance && report) |=> (r_cur == '0 && r_lines == '0),
                "line state not cleared after a report")

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for greedy_monospace_line_breaker: glyph texts go in on the input
// stream, and line reports are checked against a cycle-free predictor held in a scoreboard.
// Depends on gmlb_pkg and the block's RTL only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Width modes and wrap codes that the package leaves unnamed.
    localparam logic [1:0] MODE_AT_MOST  = 2'd1;
    localparam logic [1:0] MODE_EXACT    = 2'd2;
    localparam logic [1:0] WRAP_CHAR_ALT = 2'd3;

    localparam int unsigned LEN_MAX      = 32'd65535;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_ITEMS  = 430;

    // Scoreboard: predicts one line report per finished text and checks the block's reports.
    class line_report_board;
        logic [1:0]  wrap_policy;
        logic [1:0]  sizing_mode;
        logic        constraint_ok;
        logic [15:0] glyphs_fit;
        int unsigned open_len;
        int unsigned brk_len;
        int unsigned lines_closed;
        int unsigned longest_closed;
        logic [15:0] due_totals[$];
        logic [15:0] due_longest[$];
        int          errors;
        int          reports_checked;
        int          reg_writes;

        function new();
            wrap_policy    = gmlb_pkg::WRAP_NONE;
            sizing_mode    = gmlb_pkg::MODE_UNDEF;
            constraint_ok  = 1'b0;
            glyphs_fit     = '0;
            errors         = 0;
            reports_checked = 0;
            reg_writes     = 0;
            clear_text();
        endfunction

        function void clear_text();
            open_len       = 0;
            brk_len        = 0;
            lines_closed   = 0;
            longest_closed = 0;
        endfunction

        function int unsigned sat_inc(int unsigned v);
            return (v >= LEN_MAX) ? LEN_MAX : v + 1;
        endfunction

        function void close_line(int unsigned len);
            lines_closed = sat_inc(lines_closed);
            if (len > longest_closed) longest_closed = len;
        endfunction

        function bit allows_break(gmlb_pkg::t_cp cp);
            bit hit;
            hit = 1'b0;
            for (int i = 0; i < gmlb_pkg::NUM_BRK; i++)
                if (gmlb_pkg::BRK_CODES[i] == cp) hit = 1'b1;
            return hit;
        endfunction

        // Break rule and line limit that the registers select right now.
        function gmlb_pkg::t_rule rule_now(output int unsigned limit);
            limit = LEN_MAX;
            if (sizing_mode == gmlb_pkg::MODE_MIN) begin
                if (wrap_policy == gmlb_pkg::WRAP_NONE) return gmlb_pkg::RULE_ONE;
                if (wrap_policy == gmlb_pkg::WRAP_CHAR) begin
                    limit = 1;
                    return gmlb_pkg::RULE_CHAR;
                end
                return gmlb_pkg::RULE_BRK;
            end
            if (sizing_mode == gmlb_pkg::MODE_UNDEF || wrap_policy == gmlb_pkg::WRAP_NONE
                || !constraint_ok)
                return gmlb_pkg::RULE_ONE;
            limit = (glyphs_fit == 16'd0) ? 1 : int'(glyphs_fit);
            return (wrap_policy == gmlb_pkg::WRAP_WORD) ? gmlb_pkg::RULE_WORD
                                                        : gmlb_pkg::RULE_CHAR;
        endfunction

        function void write_reg(gmlb_pkg::t_reg_idx idx, logic [31:0] value);
            reg_writes++;
            case (idx)
                gmlb_pkg::REG_WRAP_POLICY:   wrap_policy   = value[1:0];
                gmlb_pkg::REG_SIZING_MODE:   sizing_mode   = value[1:0];
                gmlb_pkg::REG_CONSTRAINT_OK: constraint_ok = value[0];
                gmlb_pkg::REG_GLYPHS_FIT:    glyphs_fit    = value[15:0];
                default: ;
            endcase
        endfunction

        // Advances the text by one accepted transaction; a finished text queues its report.
        function void add_to_text(gmlb_pkg::t_cp cp, logic no_glyph, logic last_glyph);
            int unsigned     limit;
            int unsigned     total;
            int unsigned     longest;
            gmlb_pkg::t_rule rule;
            bit              brk;
            if (!no_glyph) begin
                rule = rule_now(limit);
                brk  = allows_break(cp);
                if (rule == gmlb_pkg::RULE_WORD && open_len >= limit) begin
                    if (brk_len > 0) begin
                        close_line(brk_len);
                        open_len = open_len - brk_len;
                    end else begin
                        close_line(open_len);
                        open_len = 0;
                    end
                    brk_len = 0;
                end else if (rule == gmlb_pkg::RULE_CHAR && open_len >= limit) begin
                    close_line(open_len);
                    open_len = 0;
                    brk_len  = 0;
                end
                open_len = sat_inc(open_len);
                if (brk) brk_len = open_len;
                if (rule == gmlb_pkg::RULE_BRK && brk) begin
                    close_line(open_len);
                    open_len = 0;
                    brk_len  = 0;
                end
                if (!last_glyph) return;
            end
            total   = lines_closed;
            longest = longest_closed;
            if (open_len > 0) begin
                total = sat_inc(total);
                if (open_len > longest) longest = open_len;
            end
            if (total == 0) total = 1;
            due_totals.push_back(16'(total));
            due_longest.push_back(16'(longest));
            clear_text();
        endfunction

        function void check_report(logic [15:0] line_total, logic [15:0] longest_line);
            logic [15:0] want_total;
            logic [15:0] want_longest;
            if (due_totals.size() == 0) begin
                errors++;
                $error("Unexpected report: line_total %0d, longest_line %0d",
                       line_total, longest_line);
                return;
            end
            want_total   = due_totals.pop_front();
            want_longest = due_longest.pop_front();
            reports_checked++;
            if (line_total !== want_total) begin
                errors++;
                $error("line_total mismatch: expected %0d, actual %0d", want_total, line_total);
            end
            if (longest_line !== want_longest) begin
                errors++;
                $error("longest_line mismatch: expected %0d, actual %0d",
                       want_longest, longest_line);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [20:0] codepoint, [23:21] zero
    logic        s_axis_tlast = 1'b0;  // last_glyph
    logic [0:0]  s_axis_tuser = '0;    // [0] no_glyph
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] line_total, [31:16] longest_line

    line_report_board board;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_items = 0;
    int texts_sent = 0;

    greedy_monospace_line_breaker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Report side: checks each accepted transaction and drives tready, with long hold-offs
    // on request.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_report(m_axis_tdata[15:0], m_axis_tdata[31:16]);
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offers one glyph transaction, after an optional gap, and waits until it is taken.
    task automatic send_item(input gmlb_pkg::t_cp cp, input logic no_glyph,
                             input logic last_glyph);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cp};
        s_axis_tlast  <= last_glyph;
        s_axis_tuser  <= no_glyph;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.add_to_text(cp, no_glyph, last_glyph);
        sent_items++;
        if (no_glyph || last_glyph) texts_sent++;
    endtask

    task automatic send_string(input string s, input bit close_text);
        for (int i = 0; i < s.len(); i++)
            send_item(gmlb_pkg::t_cp'(s[i]), 1'b0, close_text && (i == s.len() - 1));
    endtask

    // Stops the input stream and lets every report and pending update drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.due_totals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup phase, access phase, then the port goes idle.
    task automatic reg_write(input gmlb_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] wrap, input logic [1:0] mode,
                                  input logic ok, input logic [15:0] fit);
        settle();
        reg_write(gmlb_pkg::REG_WRAP_POLICY, {30'd0, wrap});
        reg_write(gmlb_pkg::REG_SIZING_MODE, {30'd0, mode});
        reg_write(gmlb_pkg::REG_CONSTRAINT_OK, {31'd0, ok});
        reg_write(gmlb_pkg::REG_GLYPHS_FIT, {16'd0, fit});
    endtask

    function automatic logic [15:0] rand_fit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return 16'($urandom_range(12, 1));
        if (pick < 70) return 16'd0;
        if (pick < 80) return 16'hffff;
        return 16'($urandom_range(16'hffff));
    endfunction

    task automatic random_settings();
        apply_settings(2'($urandom_range(3)), 2'($urandom_range(3)),
                       ($urandom_range(9) != 0), rand_fit());
    endtask

    // Mostly break glyphs and letters; the rest spans the whole codepoint range or sits
    // one bit away from a break codepoint.
    function automatic gmlb_pkg::t_cp rand_codepoint();
        int            pick;
        gmlb_pkg::t_cp code;
        pick = $urandom_range(99);
        code = gmlb_pkg::BRK_CODES[$urandom_range(gmlb_pkg::NUM_BRK - 1)];
        if (pick < 35) return code;
        if (pick < 70) return gmlb_pkg::t_cp'($urandom_range(8'h7a, 8'h61));
        if (pick < 85) return gmlb_pkg::t_cp'($urandom_range(21'h1fffff));
        return code ^ (gmlb_pkg::t_cp'(1) << $urandom_range(gmlb_pkg::CP_BITS - 1));
    endfunction

    // One random text: its end is a final glyph or a no-glyph transaction, and now and
    // then a register changes while the text is open.
    task automatic random_text();
        int  glyphs;
        int  change_at;
        bit  ends_empty;
        ends_empty = ($urandom_range(99) < 15);
        glyphs = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(20);
        if (!ends_empty && glyphs == 0) glyphs = 1;
        change_at = ($urandom_range(9) == 0) ? $urandom_range(glyphs) : -1;
        for (int i = 0; i < glyphs; i++) begin
            if (i == change_at && i > 0) begin
                settle();
                if ($urandom_range(1))
                    reg_write(gmlb_pkg::REG_GLYPHS_FIT, {16'd0, rand_fit()});
                else
                    reg_write(gmlb_pkg::REG_WRAP_POLICY, 32'($urandom_range(3)));
            end
            send_item(rand_codepoint(), 1'b0, !ends_empty && (i == glyphs - 1));
        end
        if (ends_empty) send_item(rand_codepoint(), 1'b1, 1'($urandom_range(1)));
    endtask

    task automatic random_phase(input int src_pct, input int snk_pct);
        int target;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        target = sent_items + PHASE_ITEMS;
        while (sent_items < target) begin
            if ($urandom_range(7) == 0) random_settings();
            random_text();
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty text, the top codepoint, and glyphs ended by a no-glyph item.
        send_item('0, 1'b1, 1'b0);
        send_item(21'h1fffff, 1'b0, 1'b1);
        send_string("a-", 1'b0);
        send_item('0, 1'b1, 1'b1);

        // Word wrap: a break at a space, then a word longer than the limit.
        apply_settings(gmlb_pkg::WRAP_WORD, MODE_AT_MOST, 1'b1, 16'd3);
        send_string("ab cdefg", 1'b1);

        // Limit lowered while a line is open: the open line closes as it stands.
        apply_settings(gmlb_pkg::WRAP_WORD, MODE_AT_MOST, 1'b1, 16'd8);
        send_string("abcd", 1'b0);
        settle();
        reg_write(gmlb_pkg::REG_GLYPHS_FIT, 32'd2);
        send_string("e", 1'b1);

        // Character wrap with a zero fit, which means one glyph per line.
        apply_settings(gmlb_pkg::WRAP_CHAR, MODE_EXACT, 1'b1, 16'd0);
        send_string("xyz", 1'b1);

        // Min content, word and character policies.
        apply_settings(gmlb_pkg::WRAP_WORD, gmlb_pkg::MODE_MIN, 1'b0, 16'hffff);
        send_string("a,b", 1'b1);
        apply_settings(gmlb_pkg::WRAP_CHAR, gmlb_pkg::MODE_MIN, 1'b0, 16'hffff);
        send_string("ab", 1'b1);

        // Random texts under two idling patterns.
        random_phase(7, 65);
        random_phase(65, 7);

        // The report side holds off while short texts keep coming, so the block backs up.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        apply_settings(WRAP_CHAR_ALT, MODE_AT_MOST, 1'b1, 16'd1);
        hold_req++;
        for (int i = 0; i < 12; i++) send_item(rand_codepoint(), 1'b0, 1'b1);
        random_phase(0, 0);

        settle();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d stream transactions in %0d texts, %0d reports checked,",
                 sent_items, texts_sent, board.reports_checked);
        $display("%0d register writes across all wrap policies, width modes and fit extremes.",
                 board.reg_writes);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
